@@ src/gcv_pkg.sv @@
// Shared constants, types and helpers for the ground contact vote block.
`default_nettype none

package gcv_pkg;

   // Vote register length and the width of its set-bit count
   localparam int VOTE_DEPTH = 8;
   localparam int VOTE_CNT_W = $clog2(VOTE_DEPTH + 1);

   // Group framing: three rounds of three channels
   localparam int GROUP_LEN  = 9;
   localparam int ROUND_LEN  = 3;
   localparam int POS_W      = 4;
   localparam int CAL_GROUPS = 3;

   // Margin register reset value
   localparam logic [14:0] MARGIN_RESET = 15'd50;

   // Divide by three: x * 43691 >> 17 is exact for 0 <= x < 2**17
   localparam logic [15:0] DIV3_MUL   = 16'd43691;
   localparam int          DIV3_SHIFT = 17;

   // Channel slot codes within a round
   localparam logic [1:0] SLOT_FIRST = 2'd0;
   localparam logic [1:0] SLOT_MID   = 2'd1;
   localparam logic [1:0] SLOT_LAST  = 2'd2;

   typedef logic signed [15:0] dist_type;
   typedef logic signed [16:0] trig_type;
   typedef logic signed [17:0] sum_type;
   typedef logic [POS_W-1:0]   pos_type;
   typedef logic [VOTE_DEPTH-1:0] vote_type;

   // Group-end event handed from the minimum unit to the vote logic
   typedef struct packed {
      logic     valid;
      logic     busy;
      dist_type average;
   } avg_event_type;

   // Map a group position to its channel slot within the round
   function automatic logic [1:0] round_slot(input pos_type pos);
      logic [1:0] slot;
      case (pos)
         4'd0, 4'd3, 4'd6: slot = SLOT_FIRST;
         4'd1, 4'd4, 4'd7: slot = SLOT_MID;
         4'd2, 4'd5, 4'd8: slot = SLOT_LAST;
         default:          slot = SLOT_FIRST;
      endcase
      return slot;
   endfunction

   // Truncating divide by three of a non-negative value below 2**17
   function automatic dist_type div3(input logic [16:0] x);
      logic [32:0] prod;
      prod = {16'b0, x} * {17'b0, DIV3_MUL};
      return dist_type'(prod[DIV3_SHIFT +: 16]);
   endfunction

   // Count the set bits of the vote register
   function automatic logic [VOTE_CNT_W-1:0] vote_count(input vote_type v);
      logic [VOTE_CNT_W-1:0] n;
      n = '0;
      for (int i = 0; i < VOTE_DEPTH; i++) begin
         n = n + VOTE_CNT_W'(v[i]);
      end
      return n;
   endfunction

endpackage

`default_nettype wire

@@ src/gcv_channels.sv @@
// Valid/ready channel interfaces for readings and results.
`default_nettype none

interface gcv_req_if;
   logic               valid;
   logic               ready;
   gcv_pkg::dist_type  distance;

   modport source (output valid, output distance, input ready);
   modport sink   (input valid, input distance, output ready);
endinterface

interface gcv_rsp_if;
   logic               valid;
   logic               ready;
   gcv_pkg::dist_type  average_distance;
   logic               on_ground;
   logic               calibrating;
   gcv_pkg::trig_type  trigger_distance;

   modport source (output valid, output average_distance, output on_ground,
                   output calibrating, output trigger_distance, input ready);
   modport sink   (input valid, input average_distance, input on_ground,
                   input calibrating, input trigger_distance, output ready);
endinterface

`default_nettype wire

@@ src/gcv_group_min.sv @@
// Round minimum tracking, minima sum and held average for one group.
`default_nettype none

module gcv_group_min (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              take,
   input  wire gcv_pkg::dist_type distance,
   input  wire gcv_pkg::pos_type  position,
   output gcv_pkg::avg_event_type avg_event
);

   logic                in_valid_ff;
   gcv_pkg::dist_type   in_dist_ff;
   gcv_pkg::pos_type    in_pos_ff;

   gcv_pkg::dist_type   rm_ff, rm_in;
   gcv_pkg::sum_type    msum_ff, msum_in;
   logic                fin_valid_ff, fin_valid_in;
   gcv_pkg::sum_type    fin_sum_ff, fin_sum_in;
   logic                avg_valid_ff;
   gcv_pkg::dist_type   held_ff, held_in;

   logic [1:0]          slot;
   logic                group_end;

   // Hold the accepted reading and its position
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= take;
      end
      if (take) begin
         in_dist_ff <= distance;
         in_pos_ff  <= position;
      end
   end

   // Update round minimum and minima sum; close the group on its last reading
   always_comb begin
      slot         = gcv_pkg::round_slot(in_pos_ff);
      group_end    = in_pos_ff == gcv_pkg::POS_W'(gcv_pkg::GROUP_LEN - 1);
      rm_in        = rm_ff;
      msum_in      = msum_ff;
      fin_valid_in = 1'b0;
      fin_sum_in   = fin_sum_ff;
      if (in_valid_ff) begin
         if (slot == gcv_pkg::SLOT_FIRST) begin
            rm_in = in_dist_ff;
         end else if (in_dist_ff < rm_ff && in_dist_ff > 16'sd0) begin
            rm_in = in_dist_ff;
         end
         if (slot == gcv_pkg::SLOT_LAST) begin
            msum_in = msum_ff + gcv_pkg::sum_type'(rm_in);
         end
         if (group_end) begin
            fin_valid_in = 1'b1;
            fin_sum_in   = msum_in;
            msum_in      = '0;
         end
      end
   end

   // Divide a positive minima sum by three, else keep the held average
   always_comb begin
      held_in = held_ff;
      if (fin_valid_ff && fin_sum_ff > 18'sd0) begin
         held_in = gcv_pkg::div3(fin_sum_ff[16:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rm_ff        <= '0;
         msum_ff      <= '0;
         fin_valid_ff <= 1'b0;
         avg_valid_ff <= 1'b0;
         held_ff      <= '0;
      end else begin
         rm_ff        <= rm_in;
         msum_ff      <= msum_in;
         fin_valid_ff <= fin_valid_in;
         avg_valid_ff <= fin_valid_ff;
         held_ff      <= held_in;
      end
      fin_sum_ff <= fin_sum_in;
   end

   assign avg_event.valid   = avg_valid_ff;
   assign avg_event.busy    = (in_valid_ff && group_end) || fin_valid_ff || avg_valid_ff;
   assign avg_event.average = held_ff;

endmodule

`default_nettype wire

@@ src/ground_contact_vote.sv @@
// Top level: ground contact detector with calibration and majority vote.
`default_nettype none

// Channel   Direction  Payload                                        Handshake
// req_chan  in         distance (16 s)                                valid/ready
// rsp_chan  out        average_distance, on_ground, calibrating,      valid/ready
//                      trigger_distance (17 s)
// csr       in         csr_wr_data (15 u) ground margin               csr_wr_en
//
// One reading is accepted per cycle except when the ninth one stalls. A result
// leaves after the ninth reading of a group is accepted, through a pipeline of
// input register, minima sum, divide by three, calibration/vote and result register.
// The ninth reading of a group waits while an earlier group is still in the pipeline or its result is unclaimed.
// Reset is synchronous; it clears the vote register to all ones and starts
// calibration again.

module ground_contact_vote (
   input  wire logic         clock,
   input  wire logic         reset,
   gcv_req_if.sink           req_chan,
   gcv_rsp_if.source         rsp_chan,
   input  wire logic         csr_wr_en,
   input  wire logic [14:0]  csr_wr_data
);

   logic [14:0]              margin_val_ff;
   gcv_pkg::pos_type         pos_ff, pos_in;
   logic                     take;
   logic                     is_last;
   gcv_pkg::avg_event_type   avg_event;

   logic [1:0]               cnt_ff, cnt_in;
   gcv_pkg::sum_type         cs_ff, cs_in;
   gcv_pkg::vote_type        vote_ff, vote_in;
   logic                     ev_valid_ff;
   logic                     ev_calib_ff, ev_calib_in;
   logic                     ev_third_ff, ev_third_in;
   gcv_pkg::dist_type        ev_avg_ff;

   gcv_pkg::trig_type        trig_ff, trig_in;
   gcv_pkg::dist_type        quot;

   logic                     rsp_valid_ff;
   gcv_pkg::dist_type        rsp_avg_ff;
   logic                     rsp_ground_ff;
   logic                     rsp_calib_ff;
   gcv_pkg::trig_type        rsp_trig_ff;
   logic                     vote_bit;

   // Hold the ground margin
   always_ff @(posedge clock) begin
      if (reset) begin
         margin_val_ff <= gcv_pkg::MARGIN_RESET;
      end else if (csr_wr_en) begin
         margin_val_ff <= csr_wr_data;
      end
   end

   // Track the position within the group; stall the last reading while the pipeline is busy or a result is unclaimed
   assign is_last = pos_ff >= gcv_pkg::POS_W'(gcv_pkg::GROUP_LEN - 1);
   assign req_chan.ready = !is_last ||
                           (!avg_event.busy && !ev_valid_ff &&
                            (!rsp_valid_ff || rsp_chan.ready));
   assign take = req_chan.valid && req_chan.ready;

   always_comb begin
      pos_in = pos_ff;
      if (take) begin
         pos_in = is_last ? '0 : pos_ff + gcv_pkg::POS_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

   gcv_group_min u_group_min (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .distance  (req_chan.distance),
      .position  (is_last ? gcv_pkg::POS_W'(gcv_pkg::GROUP_LEN - 1) : pos_ff),
      .avg_event (avg_event)
   );

   // Calibrate on the first groups, then vote on each later group
   always_comb begin
      cnt_in      = cnt_ff;
      cs_in       = cs_ff;
      vote_in     = vote_ff;
      ev_calib_in = 1'b0;
      ev_third_in = 1'b0;
      vote_bit    = gcv_pkg::trig_type'(avg_event.average) < trig_ff;
      if (avg_event.valid) begin
         if (cnt_ff < 2'(gcv_pkg::CAL_GROUPS)) begin
            ev_calib_in = 1'b1;
            cs_in       = cs_ff + gcv_pkg::sum_type'(avg_event.average);
            cnt_in      = cnt_ff + 2'd1;
            ev_third_in = cnt_ff == 2'(gcv_pkg::CAL_GROUPS - 1);
         end else begin
            vote_in = (vote_ff << 1) | gcv_pkg::vote_type'(vote_bit);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff      <= '0;
         cs_ff       <= '0;
         vote_ff     <= '1;
         ev_valid_ff <= 1'b0;
      end else begin
         cnt_ff      <= cnt_in;
         cs_ff       <= cs_in;
         vote_ff     <= vote_in;
         ev_valid_ff <= avg_event.valid;
      end
      ev_calib_ff <= ev_calib_in;
      ev_third_ff <= ev_third_in;
      ev_avg_ff   <= avg_event.average;
   end

   // Form the trigger distance when calibration completes
   always_comb begin
      quot    = gcv_pkg::div3(cs_ff[16:0]);
      trig_in = trig_ff;
      if (ev_valid_ff && ev_third_ff) begin
         trig_in = gcv_pkg::trig_type'({1'b0, quot}) +
                   gcv_pkg::trig_type'({2'b0, margin_val_ff});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         trig_ff <= '0;
      end else begin
         trig_ff <= trig_in;
      end
   end

   // Load the result register; drop it once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ev_valid_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (ev_valid_ff) begin
         rsp_avg_ff    <= ev_avg_ff;
         rsp_ground_ff <= gcv_pkg::vote_count(vote_ff) >
                          gcv_pkg::VOTE_CNT_W'(gcv_pkg::VOTE_DEPTH / 2);
         rsp_calib_ff  <= ev_calib_ff;
         rsp_trig_ff   <= trig_in;
      end
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.average_distance = rsp_avg_ff;
   assign rsp_chan.on_ground        = rsp_ground_ff;
   assign rsp_chan.calibrating      = rsp_calib_ff;
   assign rsp_chan.trigger_distance = rsp_trig_ff;

endmodule

`default_nettype wire
